// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
// each expects clk and rst in scope, checks are off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/ocrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ocrb_pkg
// types and constants shared by the capture ring buffer modules
// ----------------------------------------------------------------------------
package ocrb_pkg;

  // request codes
  localparam logic [2:0] REQ_PUSH    = 3'd0;
  localparam logic [2:0] REQ_TAKE    = 3'd1;
  localparam logic [2:0] REQ_READ    = 3'd2;
  localparam logic [2:0] REQ_DISCARD = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_NOTHING = 2'd3;

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  // field widths
  localparam int CAP_W     = 13;
  localparam int CAP_MAX   = 8191;
  localparam int SAMPLE_W  = 16;
  localparam int SWIDTH_W  = 6;
  localparam int RATE_W    = 19;
  localparam int CHAN_W    = 4;
  localparam int COUNT_W   = 32;

  localparam logic [SWIDTH_W-1:0] ACCEPT_WIDTH  = 6'd16;
  localparam logic [CAP_W-1:0]    CAP_RESET     = 13'd4096;
  localparam logic [COUNT_W-1:0]  TIMEOUT_RESET = 32'd48000;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic commit;    // execute the held item and load the result register
    logic cfg_write; // configuration register write
  } ocrb_cmd_t;

endpackage

// ===== hw/rtl/ocrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ocrb_ctrl
// handshake controller: item capture, execute and result register occupancy
// ----------------------------------------------------------------------------
module ocrb_ctrl import ocrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  output ocrb_cmd_t cmd
);

  `include "assert_macros.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign out_free      = !out_valid || !out_stall;
  assign in_stall      = (state != S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign cmd.capture   = in_valid && (state == S_IDLE);
  assign cmd.commit    = (state == S_EXEC) && out_free;
  assign cmd.cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid)
  `ASSERT_NEXT(a_capture_goes_exec, cmd.capture, state == S_EXEC)
  `ASSERT_NEXT(a_exec_waits, (state == S_EXEC) && !cmd.commit, state == S_EXEC)

endmodule

// ===== hw/rtl/ocrb_datapath.sv =====
// ----------------------------------------------------------------------------
// ocrb_datapath
// item register, ring state, sample store and result register
// ----------------------------------------------------------------------------
module ocrb_datapath import ocrb_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ocrb_cmd_t                  cmd,
  input  logic                       cfg_index,
  input  logic [COUNT_W-1:0]         cfg_data,
  input  logic [2:0]                 req_type,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [SWIDTH_W-1:0]        sample_width,
  input  logic [RATE_W-1:0]          rate_in,
  input  logic [CHAN_W-1:0]          channels_in,
  output logic [1:0]                 status,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       last_sample,
  output logic [RATE_W-1:0]          rate_out,
  output logic [CHAN_W-1:0]          channels_out,
  output logic [COUNT_W-1:0]         dropped_count,
  output logic [CAP_W-1:0]           fill_level,
  output logic                       is_recording,
  output logic                       audio_available
);

  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = (AW > CAP_W) ? CAP_W : AW;
  localparam logic [CAP_W-1:0] DEPTH_LIM = CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

  // held item
  logic [2:0]                 req_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [SWIDTH_W-1:0]        width_q;
  logic [RATE_W-1:0]          rate_q;
  logic [CHAN_W-1:0]          chan_q;

  // configuration
  logic [CAP_W-1:0]   capacity;
  logic [COUNT_W-1:0] timeout;

  // ring state
  logic [IW-1:0]      head;
  logic [CAP_W-1:0]   level;
  logic [RATE_W-1:0]  lrate;
  logic [CHAN_W-1:0]  lchan;
  logic [COUNT_W-1:0] dropped;
  logic [COUNT_W-1:0] elapsed;
  logic               recording;
  logic               draining;

  logic [IW-1:0]      head_next;
  logic [CAP_W-1:0]   level_next;
  logic [RATE_W-1:0]  lrate_next;
  logic [CHAN_W-1:0]  lchan_next;
  logic [COUNT_W-1:0] dropped_next;
  logic [COUNT_W-1:0] elapsed_next;
  logic               recording_next;
  logic               draining_next;

  // store
  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       mem_we;
  logic [IW-1:0]              wr_idx;

  // result
  logic [1:0]                 st_c;
  logic signed [SAMPLE_W-1:0] sout_c;
  logic                       last_c;
  logic                       avail_c;
  logic                       isrec_c;

  // helpers
  logic [CAP_W-1:0]   eff_cap;
  logic               active;
  logic               exp_now;
  logic               ge_inc;
  logic [COUNT_W-1:0] elapsed_inc;
  logic [CAP_W-1:0]   head_ext;
  logic [CAP_W-1:0]   head_inc_ext;
  logic [IW-1:0]      head_inc;
  logic [CAP_W:0]     wr_sum;
  logic [CAP_W:0]     wr_wrap;
  logic               full;
  logic               bad_push;
  logic               mismatch;
  logic               do_clear;

  assign eff_cap      = (capacity > DEPTH_LIM) ? DEPTH_LIM : capacity;
  assign active       = recording && (eff_cap != '0) && (timeout != '0);
  assign exp_now      = elapsed >= timeout;
  assign elapsed_inc  = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign ge_inc       = elapsed_inc >= timeout;
  assign head_ext     = CAP_W'(head);
  assign head_inc_ext = head_ext + 1'b1;
  assign head_inc     = (head_inc_ext == eff_cap) ? '0 : IW'(head_inc_ext);
  assign wr_sum       = {1'b0, head_ext} + {1'b0, level};
  assign wr_wrap      = (wr_sum >= {1'b0, eff_cap}) ? wr_sum - {1'b0, eff_cap} : wr_sum;
  assign full         = level >= eff_cap;
  assign wr_idx       = full ? head : IW'(wr_wrap);
  assign bad_push     = (width_q != ACCEPT_WIDTH) || (rate_q == '0) || (chan_q == '0)
                        || !active;
  assign mismatch     = (lrate != '0) && ((lrate != rate_q) || (lchan != chan_q));

  always_comb begin
    head_next      = head;
    level_next     = level;
    lrate_next     = lrate;
    lchan_next     = lchan;
    dropped_next   = dropped;
    elapsed_next   = elapsed;
    recording_next = recording;
    draining_next  = draining;
    st_c           = ST_IGNORED;
    sout_c         = '0;
    last_c         = 1'b0;
    avail_c        = 1'b0;
    mem_we         = 1'b0;
    do_clear       = 1'b0;

    unique case (req_q)
      REQ_PUSH: begin
        if (bad_push) begin
          st_c = ST_IGNORED;
        end else if (exp_now) begin
          recording_next = 1'b0;
          do_clear       = 1'b1;
          st_c           = ST_EXPIRED;
        end else if (mismatch) begin
          st_c = ST_IGNORED;
        end else begin
          if (lrate == '0) begin
            lrate_next = rate_q;
            lchan_next = chan_q;
          end
          avail_c = (level == '0);
          mem_we  = 1'b1;
          if (full) begin
            // oldest sample is overwritten in place, head moves past it
            head_next  = head_inc;
            level_next = eff_cap;
            if (dropped != '1) dropped_next = dropped + 1'b1;
          end else begin
            level_next = level + 1'b1;
          end
          st_c = ST_OK;
        end
      end
      REQ_TAKE: begin
        if (!active) begin
          recording_next = 1'b0;
          do_clear       = 1'b1;
          st_c           = ST_NOTHING;
        end else if (exp_now) begin
          recording_next = 1'b0;
          do_clear       = 1'b1;
          st_c           = ST_EXPIRED;
        end else if ((level == '0) || (lrate == '0) || (lchan == '0)) begin
          recording_next = 1'b0;
          do_clear       = 1'b1;
          st_c           = ST_NOTHING;
        end else begin
          recording_next = 1'b0;
          draining_next  = 1'b1;
          st_c           = ST_OK;
        end
      end
      REQ_READ: begin
        if (!draining || (level == '0) || (eff_cap == '0)) begin
          st_c = ST_NOTHING;
        end else begin
          sout_c     = rd_data;
          head_next  = head_inc;
          level_next = level - 1'b1;
          st_c       = ST_OK;
          if (level == CAP_W'(1)) begin
            last_c   = 1'b1;
            do_clear = 1'b1;
          end
        end
      end
      REQ_DISCARD: begin
        recording_next = 1'b0;
        do_clear       = 1'b1;
        st_c           = ST_OK;
      end
      REQ_TICK: begin
        elapsed_next = elapsed_inc;
        st_c         = ST_OK;
        if (active && ge_inc) begin
          recording_next = 1'b0;
          do_clear       = 1'b1;
          st_c           = ST_EXPIRED;
        end
      end
      default: st_c = ST_IGNORED;
    endcase

    if (do_clear) begin
      head_next     = '0;
      level_next    = '0;
      lrate_next    = '0;
      lchan_next    = '0;
      draining_next = 1'b0;
    end

    isrec_c = recording_next && (eff_cap != '0) && (timeout != '0)
              && !((req_q == REQ_TICK) ? ge_inc : exp_now);
  end

  // held item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= req_type;
      sample_q <= sample_in;
      width_q  <= sample_width;
      rate_q   <= rate_in;
      chan_q   <= channels_in;
    end
  end

  // configuration and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      timeout   <= TIMEOUT_RESET;
      head      <= '0;
      level     <= '0;
      lrate     <= '0;
      lchan     <= '0;
      dropped   <= '0;
      elapsed   <= '0;
      recording <= 1'b1;
      draining  <= 1'b0;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        REG_CAPACITY: begin
          capacity <= cfg_data[CAP_W-1:0];
          head     <= '0;
          level    <= '0;
          lrate    <= '0;
          lchan    <= '0;
          draining <= 1'b0;
        end
        REG_TIMEOUT: timeout <= cfg_data;
        default: timeout <= timeout;
      endcase
    end else if (cmd.commit) begin
      head      <= head_next;
      level     <= level_next;
      lrate     <= lrate_next;
      lchan     <= lchan_next;
      dropped   <= dropped_next;
      elapsed   <= elapsed_next;
      recording <= recording_next;
      draining  <= draining_next;
    end
  end

  // sample store, head entry read every cycle
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      mem[AW'(wr_idx)] <= sample_q;
    end
    rd_data <= mem[AW'(head)];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= st_c;
      sample_out      <= sout_c;
      last_sample     <= last_c;
      rate_out        <= lrate_next;
      channels_out    <= lchan_next;
      dropped_count   <= dropped_next;
      fill_level      <= level_next;
      is_recording    <= isrec_c;
      audio_available <= avail_c;
    end
  end

  `ASSERT_IMPLIES(a_level_in_range, 1'b1, level <= eff_cap)
  `ASSERT_IMPLIES(a_head_in_range, eff_cap != '0, head_ext < eff_cap)
  `ASSERT_IMPLIES(a_drain_not_rec, draining, !recording)

endmodule

// ===== hw/rtl/overwriting_capture_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// overwriting_capture_ring_buffer
// capture ring buffer of 16-bit audio samples with overwrite and drop count
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ------------------------------------
//  in        to block   in_valid / in_stall   req_type sample_in sample_width
//                                             rate_in channels_in
//  out       from block out_valid / out_stall status sample_out last_sample rate_out
//                                             channels_out dropped_count fill_level
//                                             is_recording audio_available
//  cfg       to block   cfg_valid / cfg_ready cfg_index cfg_data
//
// each item first lands in the item register, then runs against the ring state
// and the registered read of the head entry
// the execute cycle waits while the result register is full and stalled; a
// result that is waiting does not stop the next item from being captured
// rst is synchronous; no clearing pass, the store is only read where written
// cfg is taken whenever the controller is idle
//
module overwriting_capture_ring_buffer import ocrb_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  // item input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 req_type,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [SWIDTH_W-1:0]        sample_width,
  input  logic [RATE_W-1:0]          rate_in,
  input  logic [CHAN_W-1:0]          channels_in,
  // result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       last_sample,
  output logic [RATE_W-1:0]          rate_out,
  output logic [CHAN_W-1:0]          channels_out,
  output logic [COUNT_W-1:0]         dropped_count,
  output logic [CAP_W-1:0]           fill_level,
  output logic                       is_recording,
  output logic                       audio_available,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [COUNT_W-1:0]         cfg_data
);

  // commands from the controller into the datapath
  ocrb_cmd_t cmd;

  // controller: capture, execute and result slot bookkeeping
  ocrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // datapath: item register, ring pointers, store and result register
  ocrb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .sample_in       (sample_in),
    .sample_width    (sample_width),
    .rate_in         (rate_in),
    .channels_in     (channels_in),
    .status          (status),
    .sample_out      (sample_out),
    .last_sample     (last_sample),
    .rate_out        (rate_out),
    .channels_out    (channels_out),
    .dropped_count   (dropped_count),
    .fill_level      (fill_level),
    .is_recording    (is_recording),
    .audio_available (audio_available)
  );

endmodule

// ===== test/overwriting_capture_ring_buffer_checker.sv =====
// ----------------------------------------------------------------------------
// overwriting_capture_ring_buffer_checker
// watches the item, result and register channels of the capture ring buffer,
// keeps its own copy of the ring state and checks every result in order
// ----------------------------------------------------------------------------
module overwriting_capture_ring_buffer_checker import ocrb_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [2:0]          req_type,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic [SWIDTH_W-1:0] sample_width,
  input  logic [RATE_W-1:0]   rate_in,
  input  logic [CHAN_W-1:0]   channels_in,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          status,
  input  logic [SAMPLE_W-1:0] sample_out,
  input  logic                last_sample,
  input  logic [RATE_W-1:0]   rate_out,
  input  logic [CHAN_W-1:0]   channels_out,
  input  logic [COUNT_W-1:0]  dropped_count,
  input  logic [CAP_W-1:0]    fill_level,
  input  logic                is_recording,
  input  logic                audio_available,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [COUNT_W-1:0]  cfg_data,
  output int                  mismatches,
  output int                  pending,
  output int                  results_checked,
  output int                  samples_read
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic [1:0]          status;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic [RATE_W-1:0]   rate;
    logic [CHAN_W-1:0]   chans;
    logic [COUNT_W-1:0]  dropped;
    logic [CAP_W-1:0]    level;
    logic                recording;
    logic                fresh;
  } capture_result_t;

  capture_result_t awaited_q[$];

  // shadow ring state
  logic [SAMPLE_W-1:0] ring [DEPTH];
  int unsigned         head;
  int unsigned         level;
  int unsigned         capacity;
  logic [RATE_W-1:0]   fmt_rate;
  logic [CHAN_W-1:0]   fmt_chans;
  logic [COUNT_W-1:0]  drops;
  logic [COUNT_W-1:0]  elapsed;
  logic [COUNT_W-1:0]  timeout;
  bit                  recording;
  bit                  draining;

  function automatic int unsigned cap_in_use();
    return (capacity > DEPTH) ? DEPTH : capacity;
  endfunction

  function automatic bit capturing();
    return recording && cap_in_use() != 0 && timeout != 0;
  endfunction

  function automatic void clear_ring();
    head      = 0;
    level     = 0;
    fmt_rate  = '0;
    fmt_chans = '0;
    draining  = 1'b0;
  endfunction

  function automatic void stop_capture();
    recording = 1'b0;
    clear_ring();
  endfunction

  function automatic void reset_ring();
    clear_ring();
    drops     = '0;
    elapsed   = '0;
    recording = 1'b1;
    capacity  = 32'(CAP_RESET);
    timeout   = TIMEOUT_RESET;
  endfunction

  function automatic capture_result_t apply_request(
    input logic [2:0]          req,
    input logic [SAMPLE_W-1:0] smp,
    input logic [SWIDTH_W-1:0] width,
    input logic [RATE_W-1:0]   rate,
    input logic [CHAN_W-1:0]   chans
  );
    capture_result_t r;
    int unsigned     cap;
    bit              header;
    cap    = cap_in_use();
    header = 1'b0;
    r      = '0;
    r.status = ST_IGNORED;
    case (req)
      REQ_PUSH: begin
        if (width != ACCEPT_WIDTH || rate == 0 || chans == 0 || !capturing()) begin
          r.status = ST_IGNORED;
        end else if (elapsed >= timeout) begin
          stop_capture();
          r.status = ST_EXPIRED;
        end else if (fmt_rate != 0 && (fmt_rate != rate || fmt_chans != chans)) begin
          r.status = ST_IGNORED;
        end else begin
          if (fmt_rate == 0) begin
            fmt_rate  = rate;
            fmt_chans = chans;
          end
          r.fresh = (level == 0);
          // full: oldest entry goes, drop count saturates
          if (level >= cap) begin
            head  = (head + 1) % cap;
            level = cap - 1;
            if (drops != '1) drops++;
          end
          ring[AW'((head + level) % cap)] = smp;
          level++;
          r.status = ST_OK;
        end
      end
      REQ_TAKE: begin
        if (!capturing()) begin
          stop_capture();
          r.status = ST_NOTHING;
        end else if (elapsed >= timeout) begin
          stop_capture();
          r.status = ST_EXPIRED;
        end else if (level == 0 || fmt_rate == 0 || fmt_chans == 0) begin
          stop_capture();
          r.status = ST_NOTHING;
        end else begin
          r.rate    = fmt_rate;
          r.chans   = fmt_chans;
          header    = 1'b1;
          recording = 1'b0;
          draining  = 1'b1;
          r.status  = ST_OK;
        end
      end
      REQ_READ: begin
        if (!draining || level == 0 || cap == 0) begin
          r.status = ST_NOTHING;
        end else begin
          r.sample = ring[AW'(head % cap)];
          head     = (head + 1) % cap;
          level--;
          r.status = ST_OK;
          if (level == 0) begin
            r.last = 1'b1;
            clear_ring();
          end
        end
      end
      REQ_DISCARD: begin
        stop_capture();
        r.status = ST_OK;
      end
      REQ_TICK: begin
        if (elapsed != '1) elapsed++;
        r.status = ST_OK;
        if (capturing() && elapsed >= timeout) begin
          stop_capture();
          r.status = ST_EXPIRED;
        end
      end
      default: ;
    endcase
    if (!header) begin
      r.rate  = fmt_rate;
      r.chans = fmt_chans;
    end
    r.dropped   = drops;
    r.level     = CAP_W'(level);
    r.recording = capturing() && elapsed < timeout;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    capture_result_t want;
    if (rst) begin
      reset_ring();
      awaited_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CAPACITY) begin
          capacity = 32'(cfg_data[CAP_W-1:0]);
          clear_ring();
        end else begin
          timeout = cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (awaited_q.size() == 0) begin
          if (mismatches < 10)
            $display("result with no item waiting: status %0h level %0h", status, fill_level);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("sample_out", 32'(want.sample), 32'(sample_out));
          check_field("last_sample", 32'(want.last), 32'(last_sample));
          check_field("rate_out", 32'(want.rate), 32'(rate_out));
          check_field("channels_out", 32'(want.chans), 32'(channels_out));
          check_field("dropped_count", want.dropped, dropped_count);
          check_field("fill_level", 32'(want.level), 32'(fill_level));
          check_field("is_recording", 32'(want.recording), 32'(is_recording));
          check_field("audio_available", 32'(want.fresh), 32'(audio_available));
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_request(req_type, sample_in, sample_width, rate_in, channels_in);
        if (req_type == REQ_READ && want.status == ST_OK) samples_read++;
        awaited_q.push_back(want);
      end
      pending <= awaited_q.size();
    end
  end

endmodule

// ===== test/overwriting_capture_ring_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// overwriting_capture_ring_buffer_tb
// drives requests and register writes into the capture ring buffer; a
// separate checker predicts each result and counts mismatches. a directed
// opening covers format locking, rejects and overwrite, then random capture
// phases at varied capacities and timeouts, and finally one randomly chosen
// way of ending the capture (take and drain, expiry, discard, empty or disabled take)
// ----------------------------------------------------------------------------
module overwriting_capture_ring_buffer_tb import ocrb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT        = 200000; // cycles before giving up
  localparam int HOLD_CYCLES  = 240;    // long receiver hold-off
  localparam int USEFUL_ITEMS = 420;    // well-formed pushes, ticks and reads in enabled phases
  localparam int TAIL_ITEMS   = 40;
  // request codes the block does not define
  localparam int REQ_SPARE_LO = 5;
  localparam int REQ_SPARE_HI = 7;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic [2:0]                 req_type     = REQ_PUSH;
  logic signed [SAMPLE_W-1:0] sample_in    = '0;
  logic [SWIDTH_W-1:0]        sample_width = '0;
  logic [RATE_W-1:0]          rate_in      = '0;
  logic [CHAN_W-1:0]          channels_in  = '0;
  logic                       out_stall    = 1'b0;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_index    = REG_CAPACITY;
  logic [COUNT_W-1:0]         cfg_data     = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic [1:0]                 status;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last_sample;
  logic [RATE_W-1:0]          rate_out;
  logic [CHAN_W-1:0]          channels_out;
  logic [COUNT_W-1:0]         dropped_count;
  logic [CAP_W-1:0]           fill_level;
  logic                       is_recording;
  logic                       audio_available;
  logic                       cfg_ready;

  int mismatches;
  int pending;
  int results_checked;
  int samples_read;

  // stimulus bookkeeping
  bit                 quiet    = 1'b0; // no idling on either side
  bit                 hold_go  = 1'b0;
  logic               hold_off = 1'b0;
  int                 cycle_count = 0;
  int                 items_sent  = 0;
  int                 ticks_sent  = 0;
  int                 useful      = 0;
  int                 phases      = 0;
  logic [RATE_W-1:0]  fmt_rate;
  logic [CHAN_W-1:0]  fmt_chans;
  string              ending = "none";

  overwriting_capture_ring_buffer dut (
    .clk, .rst,
    .in_valid, .in_stall, .req_type, .sample_in, .sample_width, .rate_in, .channels_in,
    .out_valid, .out_stall, .status, .sample_out, .last_sample, .rate_out,
    .channels_out, .dropped_count, .fill_level, .is_recording, .audio_available,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  overwriting_capture_ring_buffer_checker ring_watch (
    .clk, .rst,
    .in_valid, .in_stall, .req_type, .sample_in, .sample_width, .rate_in, .channels_in,
    .out_valid, .out_stall, .status, .sample_out, .last_sample, .rate_out,
    .channels_out, .dropped_count, .fill_level, .is_recording, .audio_available,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending, .results_checked, .samples_read
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus the long hold-off once asked for
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || (!quiet && $urandom_range(99) < 16);
    end
  end

  // long hold-off, counted here so the sender keeps offering meanwhile
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("overwriting_capture_ring_buffer_tb NOT OK");
      $finish;
    end
  end

  // one item: optional idle gap, then hold the payload until it is taken
  task automatic offer(input logic [2:0] req, input logic [SAMPLE_W-1:0] smp,
                       input logic [SWIDTH_W-1:0] width, input logic [RATE_W-1:0] rate,
                       input logic [CHAN_W-1:0] chans);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    req_type     <= req;
    sample_in    <= smp;
    sample_width <= width;
    rate_in      <= rate;
    channels_in  <= chans;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (req == REQ_TICK) ticks_sent++;
  endtask

  // one item of the given request with every other field random
  task automatic offer_random(input logic [2:0] req);
    offer(req, SAMPLE_W'($urandom), SWIDTH_W'($urandom), RATE_W'($urandom),
          CHAN_W'($urandom));
  endtask

  // wait until every item has produced its result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register writes only go in while the block has nothing in flight
  task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] value);
    settle();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_good();
    offer(REQ_PUSH, SAMPLE_W'($urandom), ACCEPT_WIDTH, fmt_rate, fmt_chans);
  endtask

  task automatic pick_format();
    fmt_rate  = RATE_W'($urandom_range(19'h7FFFF, 1));
    fmt_chans = CHAN_W'($urandom_range(15, 1));
  endtask

  // mostly well-formed pushes in the locked format, some ticks and early
  // reads, the rest rejects of every kind
  task automatic capture_item(input bit counts);
    int r;
    r = $urandom_range(99);
    if (r < 66) begin
      push_good();
    end else if (r < 74) begin
      offer_random(REQ_TICK);
    end else if (r < 82) begin
      offer_random(REQ_READ);
    end else if (r < 88) begin
      offer(REQ_PUSH, SAMPLE_W'($urandom), SWIDTH_W'($urandom), fmt_rate, fmt_chans);
    end else if (r < 94) begin
      offer(REQ_PUSH, SAMPLE_W'($urandom), ACCEPT_WIDTH, RATE_W'($urandom),
            CHAN_W'($urandom));
    end else if (r < 97) begin
      offer_random(3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO)));
    end else begin
      offer_random(REQ_PUSH);
    end
    if (counts && r < 82) useful++;
  endtask

  initial begin
    int          cap_pick;
    int          tmo_pick;
    int          n;
    int          c;
    int          pick;
    bit          mid_take;
    bit          enabled;
    logic [2:0]  req;
    logic [COUNT_W-1:0] cap_val;
    logic [COUNT_W-1:0] tmo_val;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ---- directed opening, still at reset settings ----
    fmt_rate  = 19'd48000;
    fmt_chans = 4'd2;
    offer(REQ_READ, '0, '0, '0, '0);                          // nothing to drain yet
    offer(REQ_PUSH, 16'h1234, 6'd15, fmt_rate, fmt_chans);    // wrong sample width
    offer(REQ_PUSH, 16'h1234, ACCEPT_WIDTH, '0, fmt_chans);   // zero rate
    offer(REQ_PUSH, 16'h1234, ACCEPT_WIDTH, fmt_rate, '0);    // zero channels
    offer(REQ_PUSH, 16'h7FFF, ACCEPT_WIDTH, fmt_rate, fmt_chans); // locks format
    offer(REQ_PUSH, 16'h8000, ACCEPT_WIDTH, fmt_rate, fmt_chans);
    offer(REQ_PUSH, 16'h0001, ACCEPT_WIDTH, 19'd44100, fmt_chans); // rate mismatch
    offer(REQ_PUSH, 16'hFFFF, ACCEPT_WIDTH, fmt_rate, 4'd1);       // channel mismatch
    offer(REQ_PUSH, 16'hFFFF, 6'h3F, 19'h7FFFF, 4'hF);             // all ones, bad width
    offer(REQ_TICK, '0, '0, '0, '0);
    offer(REQ_TICK, '1, '1, '1, '1);
    for (int r = REQ_SPARE_LO; r <= REQ_SPARE_HI; r++)
      offer_random(3'(r));

    // tiny ring: overwrite and drop count, format at its extremes
    write_reg(REG_CAPACITY, 2);
    fmt_rate  = '1;
    fmt_chans = '1;
    offer(REQ_PUSH, 16'h0000, ACCEPT_WIDTH, fmt_rate, fmt_chans);
    offer(REQ_PUSH, 16'hFFFF, ACCEPT_WIDTH, fmt_rate, fmt_chans);
    offer(REQ_PUSH, 16'h0001, ACCEPT_WIDTH, fmt_rate, fmt_chans);
    offer(REQ_PUSH, 16'h5555, ACCEPT_WIDTH, fmt_rate, fmt_chans);

    // zero capacity and zero timeout both disable recording
    write_reg(REG_CAPACITY, 0);
    push_good();
    offer(REQ_READ, '0, '0, '0, '0);
    write_reg(REG_CAPACITY, 3);
    write_reg(REG_TIMEOUT, 0);
    push_good();
    offer(REQ_TICK, '0, '0, '0, '0);
    write_reg(REG_TIMEOUT, '1);
    push_good();

    // ---- random capture phases, recording kept alive throughout ----
    while (useful < USEFUL_ITEMS) begin
      phases++;
      cap_pick = $urandom_range(19);
      if (cap_pick == 0) cap_val = 0;
      else if (cap_pick == 1) cap_val = 4096;
      else if (cap_pick == 2) cap_val = $urandom_range(CAP_MAX, 4097);
      else cap_val = $urandom_range(12, 1);
      tmo_pick = $urandom_range(9);
      if (tmo_pick == 0) tmo_val = 0;
      else if (tmo_pick == 1) tmo_val = '1;
      else tmo_val = $urandom_range(32'hFFFF_FFFE, 32'h0010_0000);
      if (phases == 3) cap_val = CAP_MAX;   // always see the saturated capacity once
      write_reg(REG_CAPACITY, cap_val);
      write_reg(REG_TIMEOUT, tmo_val);
      quiet   <= (phases == 4);
      enabled = (cap_val != 0 && tmo_val != 0);
      if (phases == 2) hold_go <= 1'b1;     // receiver holds off during this phase
      pick_format();
      if (!enabled) n = 12;
      else if (cap_val > 64) n = 25;
      else n = $urandom_range(70, 30);
      repeat (n) capture_item(enabled);
    end
    quiet <= 1'b0;

    // ---- end the capture one way, chosen at random ----
    c = $urandom_range(8, 1);
    write_reg(REG_CAPACITY, c);
    write_reg(REG_TIMEOUT, '1);
    pick_format();
    repeat ($urandom_range(2 * c + 2, 1)) push_good();
    pick = $urandom_range(9);
    if (pick <= 4) begin
      ending   = "take and drain";
      mid_take = ($urandom_range(3) == 0);  // sometimes a take cuts the drain short
      offer(REQ_TAKE, '0, '0, '0, '0);
      for (int k = 0; k < c + 2; k++) begin
        req = (mid_take && k == 1) ? REQ_TAKE : REQ_READ;
        offer_random(req);
      end
    end else if (pick == 5) begin
      ending = "expiry on push";
      write_reg(REG_TIMEOUT, 1);
      push_good();
    end else if (pick == 6) begin
      ending = "expiry on take";
      write_reg(REG_TIMEOUT, 1);
      offer(REQ_TAKE, '0, '0, '0, '0);
    end else if (pick == 7) begin
      ending = "expiry on tick";
      write_reg(REG_TIMEOUT, COUNT_W'(ticks_sent + 2));
      repeat (3) offer(REQ_TICK, '0, '0, '0, '0);
    end else if (pick == 8) begin
      ending = "discard";
      offer_random(REQ_DISCARD);
      offer(REQ_READ, '0, '0, '0, '0);
    end else if ($urandom_range(1) == 0) begin
      ending = "take on empty buffer";
      write_reg(REG_CAPACITY, c);           // rewrite clears the ring
      offer(REQ_TAKE, '0, '0, '0, '0);
    end else begin
      ending = "take while disabled";
      write_reg(REG_CAPACITY, 0);
      offer(REQ_TAKE, '0, '0, '0, '0);
    end

    // ---- tail: any request, recording is over by now ----
    repeat (TAIL_ITEMS) begin
      req = 3'($urandom_range(7));
      if (req == REQ_PUSH && $urandom_range(1) == 0) push_good();
      else offer_random(req);
    end

    settle();
    repeat (8) @(posedge clk);
    $display("sent %0d items over %0d capture phases with %0d ticks, ended by %s",
             items_sent, phases, ticks_sent, ending);
    $display("checked %0d results, %0d samples read back, %0d mismatches",
             results_checked, samples_read, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("overwriting_capture_ring_buffer_tb OK");
    end else begin
      $display("overwriting_capture_ring_buffer_tb NOT OK");
    end
    $finish;
  end

endmodule
